### hdl/integer_to_ascii_radix_top_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the integer-to-ASCII converter
// ---------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_RADIX_TOP_DEFINES_SVH
`define INTEGER_TO_ASCII_RADIX_TOP_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication under reset
`define ITOA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication under reset
`define ITOA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ITOA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define ITOA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

### hdl/itoa_pkg.sv
// ---------------------------------------------------------------------------
// itoa_pkg
// Shared types and constants for the integer-to-ASCII converter.
// ---------------------------------------------------------------------------
package itoa_pkg;

    localparam int STEP_BITS = 8;

    localparam logic [4:0] RADIX_MIN = 5'd2;
    localparam logic [4:0] RADIX_MAX = 5'd16;

    localparam logic [7:0] MINUS_CHAR = 8'h2D;
    localparam logic [7:0] ERR_CHAR   = 8'h00;

    localparam logic [7:0] GLYPHS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };

    typedef enum logic [2:0] {
        S_IDLE,
        S_BAD,
        S_DIV,
        S_SIGN,
        S_READ,
        S_EMIT
    } state_t;

    typedef enum logic [1:0] {
        OUT_SIGN,
        OUT_DIGIT,
        OUT_BAD
    } out_sel_t;

    typedef struct packed {
        logic     load;
        logic     div_step;
        logic     rd;
        logic     out_load;
        out_sel_t out_sel;
    } cmd_t;

    typedef struct packed {
        logic radix_bad;
        logic negative;
        logic div_last;
        logic quo_zero;
        logic out_free;
        logic rd_last;
        logic stack_nz;
    } sts_t;

endpackage

### hdl/integer_to_ascii_radix_top.sv
// Converts one signed WIDTH-bit integer per item into its ASCII text in radix
// 2 to 16, most significant character first, lower-case letters, with a
// leading '-' for negative values; zero gives "0". A radix outside 2..16
// gives a single item with character 0, last and bad_radix set. The block
// works on one conversion at a time. Each digit comes from a long division
// of the magnitude in the shared radix divider, which retires eight dividend
// bits a cycle; readout of each digit is a registered stack read, then an
// output load, and the '-' is loaded into the output register before the
// first digit is read. The next item is taken as soon as the last character
// sits in the output register.
// ---------------------------------------------------------------------------
// integer_to_ascii_radix_top
// Top level: controller and datapath of the integer-to-ASCII converter.
// ---------------------------------------------------------------------------
`include "integer_to_ascii_radix_top_defines.svh"

module integer_to_ascii_radix_top
#(
    parameter int WIDTH = 32
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    item_valid,
    output logic                    item_stall,
    input  logic signed [WIDTH-1:0] value,
    input  logic        [4:0]       radix,
    output logic                    char_valid,
    input  logic                    char_stall,
    output logic        [7:0]       character,
    output logic                    last,
    output logic                    bad_radix
);

    itoa_pkg::cmd_t cmd;
    itoa_pkg::sts_t sts;

    itoa_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    itoa_datapath #(
        .WIDTH (WIDTH)
    ) u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .value      (value),
        .radix      (radix),
        .cmd        (cmd),
        .sts        (sts),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .character  (character),
        .last       (last),
        .bad_radix  (bad_radix)
    );

    `ITOA_ASSERT_IMP(a_no_overwrite, clk, rst_n, cmd.out_load, sts.out_free, "pending character overwritten")
    `ITOA_ASSERT_NXT(a_busy_after_accept, clk, rst_n, item_valid && !item_stall, item_stall, "item taken while busy")
    `ITOA_ASSERT_IMP(a_read_nonempty, clk, rst_n, cmd.rd, sts.stack_nz, "read of empty digit stack")
    `ITOA_ASSERT_IMP(a_bad_item_form, clk, rst_n, char_valid && bad_radix, last && (character == itoa_pkg::ERR_CHAR), "malformed error item")

endmodule

### hdl/itoa_ctrl.sv
// ---------------------------------------------------------------------------
// itoa_ctrl
// Sequencer: division of each digit, sign, then stack readout, or a single error item for a bad radix.
// ---------------------------------------------------------------------------
module itoa_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  itoa_pkg::sts_t    sts,
    output itoa_pkg::cmd_t    cmd
);

    itoa_pkg::state_t state_reg;
    itoa_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= itoa_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            itoa_pkg::S_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = sts.radix_bad ? itoa_pkg::S_BAD : itoa_pkg::S_DIV;
                end
            end
            itoa_pkg::S_BAD:
            begin
                if (sts.out_free)
                begin
                    state_next = itoa_pkg::S_IDLE;
                end
            end
            itoa_pkg::S_DIV:
            begin
                if (sts.div_last && sts.quo_zero)
                begin
                    state_next = sts.negative ? itoa_pkg::S_SIGN : itoa_pkg::S_READ;
                end
            end
            itoa_pkg::S_SIGN:
            begin
                if (sts.out_free)
                begin
                    state_next = itoa_pkg::S_READ;
                end
            end
            itoa_pkg::S_READ:
            begin
                state_next = itoa_pkg::S_EMIT;
            end
            itoa_pkg::S_EMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = sts.rd_last ? itoa_pkg::S_IDLE : itoa_pkg::S_READ;
                end
            end
            default:
            begin
                state_next = itoa_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item_stall   = 1'b1;
        cmd.load     = 1'b0;
        cmd.div_step = 1'b0;
        cmd.rd       = 1'b0;
        cmd.out_load = 1'b0;
        cmd.out_sel  = itoa_pkg::OUT_DIGIT;
        case (state_reg)
            itoa_pkg::S_IDLE:
            begin
                item_stall = 1'b0;
                cmd.load   = item_valid && !sts.radix_bad;
            end
            itoa_pkg::S_BAD:
            begin
                cmd.out_load = sts.out_free;
                cmd.out_sel  = itoa_pkg::OUT_BAD;
            end
            itoa_pkg::S_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            itoa_pkg::S_SIGN:
            begin
                cmd.out_load = sts.out_free;
                cmd.out_sel  = itoa_pkg::OUT_SIGN;
            end
            itoa_pkg::S_READ:
            begin
                cmd.rd = 1'b1;
            end
            itoa_pkg::S_EMIT:
            begin
                cmd.out_load = sts.out_free;
                cmd.out_sel  = itoa_pkg::OUT_DIGIT;
            end
            default:
            begin
                item_stall = 1'b1;
            end
        endcase
    end

endmodule

### hdl/itoa_datapath.sv
// ---------------------------------------------------------------------------
// itoa_datapath
// Radix divider, digit stack and output register.
// ---------------------------------------------------------------------------
module itoa_datapath
#(
    parameter int WIDTH = 32
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic signed [WIDTH-1:0] value,
    input  logic        [4:0]       radix,
    input  itoa_pkg::cmd_t          cmd,
    output itoa_pkg::sts_t          sts,
    output logic                    char_valid,
    input  logic                    char_stall,
    output logic        [7:0]       character,
    output logic                    last,
    output logic                    bad_radix
);

    localparam int NCHUNK = (WIDTH + itoa_pkg::STEP_BITS - 1) / itoa_pkg::STEP_BITS;
    localparam int PAD_W  = NCHUNK * itoa_pkg::STEP_BITS;
    localparam int CH_W   = $clog2(NCHUNK + 1);
    localparam int CNT_W  = $clog2(WIDTH + 1);
    localparam int IDX_W  = $clog2(WIDTH);

    logic [PAD_W-1:0] div_reg;
    logic [3:0]       rem_reg;
    logic [4:0]       radix_reg;
    logic             neg_reg;
    logic [CH_W-1:0]  chunk_reg;
    logic [CNT_W-1:0] count_reg;
    logic [3:0]       rd_data_reg;
    logic             rd_last_reg;
    logic [7:0]       char_reg;
    logic             last_reg;
    logic             bad_reg;
    logic             char_valid_reg;

    logic [3:0]       stack_mem [WIDTH];

    logic [WIDTH-1:0] raw;
    logic [WIDTH-1:0] mag;
    logic [PAD_W-1:0] div_next;
    logic [3:0]       rem_next;
    logic             chunk_last;
    logic             push;
    logic [CNT_W-1:0] cnt_dec;
    logic             out_free;

    assign raw = value;
    assign mag = raw[WIDTH-1] ? (~raw + WIDTH'(1)) : raw;

    // Long division by the radix, STEP_BITS dividend bits per cycle
    always_comb
    begin
        logic [4:0]                     r;
        logic [itoa_pkg::STEP_BITS-1:0] q;
        r = {1'b0, rem_reg};
        q = '0;
        for (int i = 0; i < itoa_pkg::STEP_BITS; i++)
        begin
            r = {r[3:0], div_reg[PAD_W-1-i]};
            if (r >= radix_reg)
            begin
                r = r - radix_reg;
                q[itoa_pkg::STEP_BITS-1-i] = 1'b1;
            end
        end
        rem_next = r[3:0];
        div_next = (div_reg << itoa_pkg::STEP_BITS) | PAD_W'(q);
    end

    assign chunk_last = (chunk_reg == CH_W'(NCHUNK - 1));
    assign push       = cmd.div_step && chunk_last;
    assign cnt_dec    = count_reg - CNT_W'(1);
    assign out_free   = !char_valid_reg || !char_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_reg      <= '0;
            count_reg      <= '0;
            char_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                chunk_reg <= '0;
                count_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                chunk_reg <= chunk_last ? '0 : CH_W'(chunk_reg + CH_W'(1));
                if (chunk_last)
                begin
                    count_reg <= CNT_W'(count_reg + CNT_W'(1));
                end
            end
            else if (cmd.rd)
            begin
                count_reg <= cnt_dec;
            end

            if (cmd.out_load)
            begin
                char_valid_reg <= 1'b1;
            end
            else if (!char_stall)
            begin
                char_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            div_reg   <= PAD_W'(mag);
            rem_reg   <= '0;
            radix_reg <= radix;
            neg_reg   <= raw[WIDTH-1];
        end
        else if (cmd.div_step)
        begin
            div_reg <= div_next;
            // start the next digit from a clear remainder
            rem_reg <= chunk_last ? '0 : rem_next;
        end

        if (cmd.rd)
        begin
            rd_last_reg <= (count_reg == CNT_W'(1));
        end

        if (cmd.out_load)
        begin
            case (cmd.out_sel)
                itoa_pkg::OUT_SIGN:
                begin
                    char_reg <= itoa_pkg::MINUS_CHAR;
                    last_reg <= 1'b0;
                    bad_reg  <= 1'b0;
                end
                itoa_pkg::OUT_DIGIT:
                begin
                    char_reg <= itoa_pkg::GLYPHS[rd_data_reg];
                    last_reg <= rd_last_reg;
                    bad_reg  <= 1'b0;
                end
                default:
                begin
                    char_reg <= itoa_pkg::ERR_CHAR;
                    last_reg <= 1'b1;
                    bad_reg  <= 1'b1;
                end
            endcase
        end
    end

    // Digit stack: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            stack_mem[count_reg[IDX_W-1:0]] <= rem_next;
        end
        if (cmd.rd)
        begin
            rd_data_reg <= stack_mem[cnt_dec[IDX_W-1:0]];
        end
    end

    assign sts.radix_bad = (radix < itoa_pkg::RADIX_MIN) || (radix > itoa_pkg::RADIX_MAX);
    assign sts.negative  = neg_reg;
    assign sts.div_last  = chunk_last;
    assign sts.quo_zero  = (div_next == '0);
    assign sts.out_free  = out_free;
    assign sts.rd_last   = rd_last_reg;
    assign sts.stack_nz  = (count_reg != '0);

    assign char_valid = char_valid_reg;
    assign character  = char_reg;
    assign last       = last_reg;
    assign bad_radix  = bad_reg;

endmodule
